// File: hdl/sdspi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_pkg
// Shared types, codes and helpers for the SD card SPI-mode host.
// ----------------------------------------------------------------------------
package sdspi_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int WAKE_BYTES   = 10;
  localparam int TIMER_BITS   = 24;
  localparam int CNT_W        = 10;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_READ = 2'd1,
    OP_BYTE = 2'd2,
    OP_TICK = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    RC_OK        = 3'd0,
    RC_PARAM     = 3'd1,
    RC_NOTRDY    = 3'd2,
    RC_RDTIMEOUT = 3'd3,
    RC_INITFAIL  = 3'd4
  } rc_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_WAKE, PH_DLY_CMD0, PH_DLY_CMD8, PH_DLY_ACMD, PH_DLY_LOOP,
    PH_SEND, PH_RESP, PH_R7, PH_OCR, PH_TOKEN, PH_DATA, PH_CRC
  } phase_t;

  localparam logic [1:0] CFG_CMD_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_RD_TIMEOUT  = 2'd1;
  localparam logic [1:0] CFG_SETTLE      = 2'd2;

  localparam logic [5:0] CMD0  = 6'd0;
  localparam logic [5:0] CMD8  = 6'd8;
  localparam logic [5:0] CMD16 = 6'd16;
  localparam logic [5:0] CMD17 = 6'd17;
  localparam logic [5:0] CMD41 = 6'd41;
  localparam logic [5:0] CMD55 = 6'd55;
  localparam logic [5:0] CMD58 = 6'd58;

  typedef struct packed {
    op_t         op;
    logic        drive_ok;
    logic        count_zero;
    logic [31:0] sector;
    logic [15:0] count;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       chip_select_n;
    logic       fast_clock;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
    logic [2:0] result_code;
    logic       card_ready;
  } res_t;

  function automatic logic [7:0] cmd_byte(input logic [5:0] code,
                                          input logic [2:0] idx,
                                          input logic [31:0] blk);
    logic [31:0] arg;
    unique case (code)
      CMD8:    arg = 32'h0000_01AA;
      CMD41:   arg = 32'h4000_0000;
      CMD16:   arg = 32'(SECTOR_BYTES);
      CMD17:   arg = blk;
      default: arg = 32'd0;
    endcase
    if (idx == 3'd0) return 8'h40 | {2'b00, code};
    else if (idx == 3'd1) return arg[31:24];
    else if (idx == 3'd2) return arg[23:16];
    else if (idx == 3'd3) return arg[15:8];
    else if (idx == 3'd4) return arg[7:0];
    else if (code == CMD0) return 8'h95;
    else if (code == CMD8) return 8'h87;
    else return 8'hFF;
  endfunction

endpackage
`default_nettype wire

// File: hdl/sdspi_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_if
// Valid/ready channel interfaces for requests, results and configuration.
// ----------------------------------------------------------------------------
interface sdspi_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  drive;
  logic [31:0] sector;
  logic [15:0] count;
  logic [7:0]  rx_byte;
  modport source (output valid, op, drive, sector, count, rx_byte, input ready);
  modport sink   (input valid, op, drive, sector, count, rx_byte, output ready);
endinterface

interface sdspi_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       chip_select_n;
  logic       fast_clock;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       data_last;
  logic       done_res;
  logic [2:0] result_code;
  logic       card_ready;
  modport source (output valid, tx_valid, tx_byte, chip_select_n, fast_clock,
                  data_valid, data_byte, data_last, done_res, result_code,
                  card_ready, input ready);
  modport sink   (input valid, tx_valid, tx_byte, chip_select_n, fast_clock,
                  data_valid, data_byte, data_last, done_res, result_code,
                  card_ready, output ready);
endinterface

interface sdspi_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/sdspi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_front
// Accepts request items, classifies them and places them in a two-entry queue.
// ----------------------------------------------------------------------------
module sdspi_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  sdspi_in_if.sink           in_ch,
  output sdspi_pkg::item_t   q_item,
  output logic               q_valid,
  input  wire logic          q_pop
);
  import sdspi_pkg::*;

  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      cls;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign q_item      = mem_r[rp_r];

  always_comb begin
    cls.op         = op_t'(in_ch.op);
    cls.drive_ok   = (in_ch.drive == 8'd0);
    cls.count_zero = (in_ch.count == 16'd0);
    cls.sector     = in_ch.sector;
    cls.count      = in_ch.count;
    cls.rx_byte    = in_ch.rx_byte;
    cnt_nxt        = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push)  wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> !in_ch.ready) else $error("accept while full");
`endif
endmodule
`default_nettype wire

// File: hdl/sdspi_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdspi_back
// Card protocol sequencer: one queued item per cycle while the result register is free or taken.
// ----------------------------------------------------------------------------
module sdspi_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  sdspi_pkg::item_t  q_item,
  input  wire logic         q_valid,
  output logic              q_pop,
  sdspi_cfg_if.sink         cfg_ch,
  sdspi_out_if.source       out_ch
);
  import sdspi_pkg::*;

  logic [23:0] cmd_to_r, rd_to_r, settle_r;
  phase_t      phase_r, phase_nxt;
  logic [CNT_W-1:0] bc_r, bc_nxt;
  logic [TIMER_BITS-1:0] el_r, el_nxt, lt_r, lt_nxt, el_t, lt_t;
  logic [31:0] blk_r, blk_nxt;
  logic [15:0] left_r, left_nxt;
  logic [5:0]  cc_r, cc_nxt;
  logic [7:0]  lr_r, lr_nxt;
  logic        rdy_r, rdy_nxt, fast_r, fast_nxt, cs_r, cs_nxt;
  res_t        res_r, r;
  logic        ovalid_r, step;
  logic [7:0]  rx, resp;
  logic        cmd_res;

  assign cfg_ch.ready = 1'b1;
  assign step  = q_valid && (!ovalid_r || out_ch.ready);
  assign q_pop = step;
  assign rx    = q_item.rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_to_r <= 24'd2000000;
      rd_to_r  <= 24'd1000000;
      settle_r <= 24'd10000;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_CMD_TIMEOUT: cmd_to_r <= cfg_ch.data;
        CFG_RD_TIMEOUT:  rd_to_r  <= cfg_ch.data;
        CFG_SETTLE:      settle_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Next-state logic: mirrors one step of the protocol per item.
  always_comb begin
    phase_nxt = phase_r; bc_nxt = bc_r; el_nxt = el_r; lt_nxt = lt_r;
    blk_nxt = blk_r; left_nxt = left_r; cc_nxt = cc_r; lr_nxt = lr_r;
    rdy_nxt = rdy_r; fast_nxt = fast_r; cs_nxt = cs_r;
    r = '0;
    cmd_res = 1'b0; resp = rx;
    el_t = (el_r != TIMER_MAX) ? el_r + 1'b1 : el_r;
    lt_t = (lt_r != TIMER_MAX) ? lt_r + 1'b1 : lt_r;
    unique case (q_item.op)
      OP_INIT: begin
        if (phase_r == PH_IDLE) begin
          if (!q_item.drive_ok) begin
            r.done_res = 1'b1; r.result_code = RC_INITFAIL;
          end else begin
            fast_nxt = 1'b0; cs_nxt = 1'b1; phase_nxt = PH_WAKE; bc_nxt = '0;
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
          end
        end
      end
      OP_READ: begin
        if (phase_r == PH_IDLE) begin
          if (!q_item.drive_ok || q_item.count_zero) begin
            r.done_res = 1'b1; r.result_code = RC_PARAM;
          end else if (!rdy_r) begin
            r.done_res = 1'b1; r.result_code = RC_NOTRDY;
          end else begin
            blk_nxt = q_item.sector; left_nxt = q_item.count;
            cc_nxt = CMD17; bc_nxt = '0; phase_nxt = PH_SEND; cs_nxt = 1'b0;
            r.tx_valid = 1'b1; r.tx_byte = cmd_byte(CMD17, 3'd0, q_item.sector);
          end
        end
      end
      OP_BYTE: begin
        priority case (phase_r)
          PH_WAKE: begin
            bc_nxt = bc_r + 1'b1;
            if (bc_nxt >= CNT_W'(WAKE_BYTES)) begin
              phase_nxt = PH_DLY_CMD0; el_nxt = '0;
            end else begin
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end
          end
          PH_SEND: begin
            bc_nxt = bc_r + 1'b1;
            r.tx_valid = 1'b1;
            if (bc_nxt >= CNT_W'(6)) begin
              phase_nxt = PH_RESP; el_nxt = '0; r.tx_byte = 8'hFF;
            end else begin
              r.tx_byte = cmd_byte(cc_r, bc_nxt[2:0], blk_r);
            end
          end
          PH_RESP: begin
            if (cc_r == CMD17) begin
              if (el_r > rd_to_r) begin
                phase_nxt = PH_IDLE; cs_nxt = 1'b1;
                r.done_res = 1'b1; r.result_code = RC_RDTIMEOUT;
              end else begin
                if (rx == 8'h00) begin
                  lr_nxt = rx; phase_nxt = PH_TOKEN; el_nxt = '0;
                end
                r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
              end
            end else if (el_r > cmd_to_r) begin
              cs_nxt = 1'b1; cmd_res = 1'b1; resp = 8'hFF;
            end else if (rx[7]) begin
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end else begin
              cmd_res = 1'b1;
            end
          end
          PH_R7: begin
            bc_nxt = bc_r + 1'b1;
            if (bc_nxt >= CNT_W'(4)) begin
              if (rx == 8'hAA) begin
                phase_nxt = PH_DLY_ACMD; el_nxt = '0;
              end else begin
                phase_nxt = PH_IDLE; cs_nxt = 1'b1;
                r.done_res = 1'b1; r.result_code = RC_INITFAIL;
              end
            end else begin
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end
          end
          PH_OCR: begin
            bc_nxt = bc_r + 1'b1;
            r.tx_valid = 1'b1;
            if (bc_nxt >= CNT_W'(4)) begin
              cc_nxt = CMD16; bc_nxt = '0; phase_nxt = PH_SEND; cs_nxt = 1'b0;
              r.tx_byte = cmd_byte(CMD16, 3'd0, blk_r);
            end else begin
              r.tx_byte = 8'hFF;
            end
          end
          PH_TOKEN: begin
            if (el_r > rd_to_r) begin
              phase_nxt = PH_IDLE; cs_nxt = 1'b1;
              r.done_res = 1'b1; r.result_code = RC_RDTIMEOUT;
            end else begin
              if (rx == 8'hFE) begin
                phase_nxt = PH_DATA; bc_nxt = '0;
              end
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end
          end
          PH_DATA: begin
            r.data_valid = 1'b1; r.data_byte = rx;
            r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            bc_nxt = bc_r + 1'b1;
            if (bc_r == CNT_W'(SECTOR_BYTES - 1)) begin
              r.data_last = (left_r == 16'd1);
              phase_nxt = PH_CRC; bc_nxt = '0;
            end
          end
          PH_CRC: begin
            bc_nxt = bc_r + 1'b1;
            if (bc_nxt >= CNT_W'(2)) begin
              cs_nxt = 1'b1; blk_nxt = blk_r + 32'd1; left_nxt = left_r - 16'd1;
              if (left_nxt == 16'd0) begin
                phase_nxt = PH_IDLE;
                r.done_res = 1'b1; r.result_code = RC_OK;
              end else begin
                cc_nxt = CMD17; bc_nxt = '0; phase_nxt = PH_SEND; cs_nxt = 1'b0;
                r.tx_valid = 1'b1; r.tx_byte = cmd_byte(CMD17, 3'd0, blk_nxt);
              end
            end else begin
              r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
            end
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        el_nxt = el_t; lt_nxt = lt_t;
        if ((phase_r == PH_DLY_CMD0 || phase_r == PH_DLY_CMD8 ||
             phase_r == PH_DLY_ACMD || phase_r == PH_DLY_LOOP) &&
            (el_t >= settle_r)) begin
          bc_nxt = '0; phase_nxt = PH_SEND; cs_nxt = 1'b0; r.tx_valid = 1'b1;
          if (phase_r == PH_DLY_CMD0)      cc_nxt = CMD0;
          else if (phase_r == PH_DLY_CMD8) cc_nxt = CMD8;
          else if (phase_r == PH_DLY_ACMD) begin
            cc_nxt = CMD55; lt_nxt = '0;
          end else cc_nxt = (lr_r == 8'h00) ? CMD58 : CMD55;
          r.tx_byte = cmd_byte(cc_nxt, 3'd0, blk_r);
        end
      end
      default: ;
    endcase

    if (cmd_res) begin
      lr_nxt = resp;
      priority if (cc_r == CMD0 && resp == 8'h01) begin
        phase_nxt = PH_DLY_CMD8; el_nxt = '0;
      end else if (cc_r == CMD8 && resp == 8'h01) begin
        phase_nxt = PH_R7; bc_nxt = '0; r.tx_valid = 1'b1; r.tx_byte = 8'hFF;
      end else if (cc_r == CMD55 && resp <= 8'h01) begin
        cc_nxt = CMD41; bc_nxt = '0; phase_nxt = PH_SEND; cs_nxt = 1'b0;
        r.tx_valid = 1'b1; r.tx_byte = cmd_byte(CMD41, 3'd0, blk_r);
      end else if (cc_r == CMD41 && !(lt_r > cmd_to_r)) begin
        phase_nxt = PH_DLY_LOOP; el_nxt = '0;
      end else if (cc_r == CMD58) begin
        r.tx_valid = 1'b1;
        if (resp == 8'h00) begin
          phase_nxt = PH_OCR; bc_nxt = '0; r.tx_byte = 8'hFF;
        end else begin
          cc_nxt = CMD16; bc_nxt = '0; phase_nxt = PH_SEND; cs_nxt = 1'b0;
          r.tx_byte = cmd_byte(CMD16, 3'd0, blk_r);
        end
      end else if (cc_r == CMD16 && resp == 8'h00) begin
        fast_nxt = 1'b1; rdy_nxt = 1'b1; phase_nxt = PH_IDLE; cs_nxt = 1'b1;
        r.done_res = 1'b1; r.result_code = RC_OK;
      end else begin
        phase_nxt = PH_IDLE; cs_nxt = 1'b1;
        r.done_res = 1'b1; r.result_code = RC_INITFAIL;
      end
    end
    r.chip_select_n = cs_nxt;
    r.fast_clock    = fast_nxt;
    r.card_ready    = rdy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; bc_r <= '0; el_r <= '0; lt_r <= '0;
      blk_r <= '0; left_r <= '0; cc_r <= '0; lr_r <= 8'hFF;
      rdy_r <= 1'b0; fast_r <= 1'b0; cs_r <= 1'b1; ovalid_r <= 1'b0;
    end else begin
      if (step) begin
        phase_r <= phase_nxt; bc_r <= bc_nxt; el_r <= el_nxt; lt_r <= lt_nxt;
        blk_r <= blk_nxt; left_r <= left_nxt; cc_r <= cc_nxt; lr_r <= lr_nxt;
        rdy_r <= rdy_nxt; fast_r <= fast_nxt; cs_r <= cs_nxt;
      end
      if (step) ovalid_r <= 1'b1;
      else if (out_ch.ready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= r;
  end

  assign out_ch.valid         = ovalid_r;
  assign out_ch.tx_valid      = res_r.tx_valid;
  assign out_ch.tx_byte       = res_r.tx_byte;
  assign out_ch.chip_select_n = res_r.chip_select_n;
  assign out_ch.fast_clock    = res_r.fast_clock;
  assign out_ch.data_valid    = res_r.data_valid;
  assign out_ch.data_byte     = res_r.data_byte;
  assign out_ch.data_last     = res_r.data_last;
  assign out_ch.done_res      = res_r.done_res;
  assign out_ch.result_code   = res_r.result_code;
  assign out_ch.card_ready    = res_r.card_ready;

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> $stable(res_r)) else $error("result moved");
  a_idle_cs: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> cs_r) else $error("card selected while idle");
  a_fast_ready: assert property (@(posedge clk) disable iff (!rst_n)
    fast_r |-> rdy_r) else $error("fast clock before card ready");
`endif
endmodule
`default_nettype wire

// File: hdl/sd_spi_init_and_block_read.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sd_spi_init_and_block_read
// SD card SPI-mode host: power-up sequence and multi-sector block read.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : requests (start init, start read), byte-exchanged reports with the
//           received MISO byte, and one-microsecond ticks.
//   out_* : one result per item: next byte to send, chip select, clock
//           choice, sector data byte, completion and result code.
//   cfg_* : timeout and settle registers, written while idle.
// Throughput: one item per cycle while results are taken, set by the single-step protocol sequencer.
// Path: each item passes the queue and then the result register.
// A two-entry queue separates intake from the sequencer; a stalled receiver
// holds the result register and fills the queue before in_ready drops.
// Reset: idle, card deselected, slow clock, not ready, default registers.
// ----------------------------------------------------------------------------
module sd_spi_init_and_block_read (
  input  wire logic clk,
  input  wire logic rst_n,
  sdspi_in_if.sink     in_ch,
  sdspi_out_if.source  out_ch,
  sdspi_cfg_if.sink    cfg_ch
);
  import sdspi_pkg::*;

  item_t q_item;
  logic  q_valid, q_pop;

  sdspi_front u_front (.clk, .rst_n, .in_ch, .q_item, .q_valid, .q_pop);
  sdspi_back  u_back  (.clk, .rst_n, .q_item, .q_valid, .q_pop, .cfg_ch, .out_ch);
endmodule
`default_nettype wire
